### rtl/tcgr_pkg.sv
// Shared types, codes and constants for the text console glyph renderer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tcgr_pkg;

   // Fixed field widths
   localparam int ROW_BITS_W  = 32;
   localparam int COLOR_W     = 24;
   localparam int ADDR_W      = 32;
   localparam int COORD_W     = 16;
   localparam int DIM_W       = 12;
   localparam int GLYPH_DIM_W = 6;
   localparam int ROW_IDX_W   = 5;
   localparam int OP_W        = 2;
   localparam int BIT_IDX_W   = $clog2(ROW_BITS_W);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Parameter defaults
   localparam int MAX_GLYPH_WIDTH_DEF  = 32;
   localparam int MAX_GLYPH_HEIGHT_DEF = 32;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Request operation codes
   localparam logic [OP_W-1:0] OP_ROW     = 2'd0;
   localparam logic [OP_W-1:0] OP_NEWLINE = 2'd1;
   localparam logic [OP_W-1:0] OP_BACK    = 2'd2;

   // Response kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISP_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_BASE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR     = 3'd5;

   // Register reset values
   localparam logic [DIM_W-1:0]       DISP_WIDTH_RST   = 12'd1024;
   localparam logic [DIM_W-1:0]       DISP_HEIGHT_RST  = 12'd768;
   localparam logic [GLYPH_DIM_W-1:0] GLYPH_WIDTH_RST  = 6'd8;
   localparam logic [GLYPH_DIM_W-1:0] GLYPH_HEIGHT_RST = 6'd16;
   localparam logic [ADDR_W-1:0]      FB_BASE_RST      = 32'd0;
   localparam logic [COLOR_W-1:0]     BG_COLOR_RST     = 24'd0;

   typedef struct packed {
      logic [DIM_W-1:0]       disp_width;
      logic [DIM_W-1:0]       disp_height;
      logic [GLYPH_DIM_W-1:0] glyph_width;
      logic [GLYPH_DIM_W-1:0] glyph_height;
      logic [ADDR_W-1:0]      fb_base;
      logic [COLOR_W-1:0]     bg_color;
   } tcgr_cfg_type;

   // One queued render command: an optional row of pixels, then an optional clear
   typedef struct packed {
      logic                  draw;
      logic                  clear;
      logic [ADDR_W-1:0]     line_base;
      logic [COORD_W-1:0]    x0;
      logic [BIT_IDX_W-1:0]  last_idx;
      logic [ROW_BITS_W-1:0] bits;
      logic [COLOR_W-1:0]    fg;
   } tcgr_cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_PIXEL = 3'b010,
      BK_CLEAR = 3'b100
   } tcgr_back_state_type;

endpackage

`default_nettype wire

### rtl/tcgr_if.sv
// Valid/ready channel interfaces for render requests and pixel responses.
// Depends on tcgr_pkg for field widths.
`default_nettype none

interface tcgr_req_if;
   import tcgr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [ROW_BITS_W-1:0] row_bits;
   logic [ROW_IDX_W-1:0]  row_index;
   logic                  advance;
   logic [COLOR_W-1:0]    color;

   modport source (output valid, op, row_bits, row_index, advance, color, input ready);
   modport sink (input valid, op, row_bits, row_index, advance, color, output ready);
endinterface

interface tcgr_rsp_if;
   import tcgr_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [ADDR_W-1:0]  address;
   logic [COLOR_W-1:0] pixel_color;
   logic               last;

   modport source (output valid, kind, address, pixel_color, last, input ready);
   modport sink (input valid, kind, address, pixel_color, last, output ready);
endinterface

`default_nettype wire

### rtl/tcgr_front.sv
// Front end: accepts requests, keeps the text cursor and builds render commands.
// Depends on tcgr_pkg and the request channel interface.
`default_nettype none

module tcgr_front #(
   parameter int MAX_GLYPH_WIDTH  = tcgr_pkg::MAX_GLYPH_WIDTH_DEF,
   parameter int MAX_GLYPH_HEIGHT = tcgr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   tcgr_req_if.sink                  req,
   input  var  tcgr_pkg::tcgr_cfg_type cfg,
   input  wire logic                 q_full,
   output logic                      q_push,
   output tcgr_pkg::tcgr_cmd_type    q_cmd
);
   import tcgr_pkg::*;

   localparam logic [GLYPH_DIM_W-1:0] MAXW = GLYPH_DIM_W'(MAX_GLYPH_WIDTH);
   localparam logic [GLYPH_DIM_W-1:0] MAXH = GLYPH_DIM_W'(MAX_GLYPH_HEIGHT);

   logic [COORD_W-1:0]     cursor_x_ff, cursor_x_in;
   logic [COORD_W-1:0]     cursor_y_ff, cursor_y_in;
   logic                   accept;
   logic [COORD_W-1:0]     gw16, gh16;
   logic [COORD_W-1:0]     adv_x, nl_y, py;
   logic                   adv_wrap, nl_wrap, do_nl, clear;
   logic [GLYPH_DIM_W-1:0] w_raw, w;
   logic                   row_ok, draw;
   logic [23:0]            row_prod;
   logic [25:0]            row_tri;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   assign gw16  = {{(COORD_W-GLYPH_DIM_W){1'b0}}, cfg.glyph_width};
   assign gh16  = {{(COORD_W-GLYPH_DIM_W){1'b0}}, cfg.glyph_height};
   assign adv_x = cursor_x_ff + gw16;
   assign nl_y  = cursor_y_ff + gh16;
   assign adv_wrap = $signed({2'b00, adv_x}) >
                     ($signed({6'd0, cfg.disp_width}) - $signed({12'd0, cfg.glyph_width}));
   assign nl_wrap  = $signed({2'b00, nl_y}) >
                     ($signed({6'd0, cfg.disp_height}) - $signed({12'd0, cfg.glyph_height}));
   assign do_nl = (req.op == OP_NEWLINE) || ((req.op == OP_ROW) && req.advance && adv_wrap);
   assign clear = do_nl && nl_wrap;

   // Cursor update
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      case (req.op)
         OP_ROW: begin
            if (req.advance) begin
               cursor_x_in = adv_x;
            end
         end
         OP_BACK: begin
            cursor_x_in = cursor_x_ff - gw16;
         end
         default: begin
         end
      endcase
      if (do_nl) begin
         cursor_x_in = '0;
         cursor_y_in = nl_wrap ? '0 : nl_y;
      end
   end

   // Row geometry
   assign w_raw  = {cfg.glyph_width[5:3], 3'b000};
   assign w      = (w_raw > MAXW) ? MAXW : w_raw;
   assign py     = cursor_y_ff + {{(COORD_W-ROW_IDX_W){1'b0}}, req.row_index};
   assign row_ok = ({1'b0, req.row_index} < cfg.glyph_height) &&
                   ({1'b0, req.row_index} < MAXH) &&
                   (py < {{(COORD_W-DIM_W){1'b0}}, cfg.disp_height});
   assign draw   = (req.op == OP_ROW) && row_ok && (w != '0);

   // A drawn row lies above the bottom edge, so its line number fits in DIM_W bits
   assign row_prod = {12'd0, py[DIM_W-1:0]} * {12'd0, cfg.disp_width};
   assign row_tri  = {1'b0, row_prod, 1'b0} + {2'b00, row_prod};

   always_comb begin
      q_cmd.draw      = draw;
      q_cmd.clear     = clear;
      q_cmd.line_base = cfg.fb_base + {6'd0, row_tri};
      q_cmd.x0        = cursor_x_ff;
      q_cmd.last_idx  = BIT_IDX_W'(w - 6'd1);
      q_cmd.bits      = req.row_bits;
      q_cmd.fg        = req.color;
   end

   // Only commands that draw a row or clear the screen enter the queue
   assign q_push = accept && (draw || clear);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else if (accept) begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tcgr_queue.sv
// Short command queue decoupling the front end from the pixel back end.
// Depends on tcgr_pkg for the command type and depth.
`default_nettype none

module tcgr_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  var  tcgr_pkg::tcgr_cmd_type wr_cmd,
   input  wire logic               pop,
   output tcgr_pkg::tcgr_cmd_type  rd_cmd,
   output logic                    full,
   output logic                    empty
);
   import tcgr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   tcgr_cmd_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full   = (count_ff == DEPTH_CNT);
   assign empty  = (count_ff == '0);
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/tcgr_back.sv
// Back end: walks each queued command one pixel per cycle into a free response register.
// Depends on tcgr_pkg and the response channel interface.
`default_nettype none

module tcgr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  var  tcgr_pkg::tcgr_cfg_type cfg,
   input  var  tcgr_pkg::tcgr_cmd_type q_cmd,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   tcgr_rsp_if.source                rsp
);
   import tcgr_pkg::*;

   tcgr_back_state_type  state_ff, state_in;
   tcgr_cmd_type         item_ff;
   logic [COORD_W-1:0]   px_ff, px_in;
   logic [BIT_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff;
   logic                 kind_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic                 last_ff;

   logic                 out_free, visible, pix_last, emit_pix, emit_clr, step, done_now;
   logic [COORD_W-1:0]   sw16;
   logic [COORD_W+1:0]   px_tri;
   logic [ADDR_W-1:0]    pix_addr;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign sw16     = {{(COORD_W-DIM_W){1'b0}}, cfg.disp_width};
   assign visible  = px_ff < sw16;
   // A visible pixel is the final one when the row ends or the next one is off the right edge
   assign pix_last = (idx_ff == '0) || ((px_ff + 1'b1) == sw16);
   assign px_tri   = {1'b0, px_ff, 1'b0} + {2'b00, px_ff};
   assign pix_addr = item_ff.line_base + {{(ADDR_W-COORD_W-2){1'b0}}, px_tri};

   always_comb begin
      state_in = state_ff;
      px_in    = px_ff;
      idx_in   = idx_ff;
      emit_pix = 1'b0;
      emit_clr = 1'b0;
      step     = 1'b0;
      done_now = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
         end
         BK_PIXEL: begin
            step     = !visible || out_free;
            emit_pix = visible && out_free;
            if (step) begin
               if (idx_ff == '0) begin
                  if (item_ff.clear) begin
                     state_in = BK_CLEAR;
                  end else begin
                     done_now = 1'b1;
                     state_in = BK_IDLE;
                  end
               end else begin
                  idx_in = idx_ff - 1'b1;
                  px_in  = px_ff + 1'b1;
               end
            end
         end
         BK_CLEAR: begin
            if (out_free) begin
               emit_clr = 1'b1;
               done_now = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      q_pop = ((state_ff == BK_IDLE) || done_now) && !q_empty;
      if (q_pop) begin
         px_in    = q_cmd.x0;
         idx_in   = q_cmd.last_idx;
         state_in = q_cmd.draw ? BK_PIXEL : BK_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_pix || emit_clr) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff  <= px_in;
      idx_ff <= idx_in;
      if (q_pop) begin
         item_ff <= q_cmd;
      end
      if (emit_pix) begin
         kind_ff  <= KIND_PIXEL;
         addr_ff  <= pix_addr;
         color_ff <= item_ff.bits[idx_ff] ? item_ff.fg : cfg.bg_color;
         last_ff  <= pix_last && !item_ff.clear;
      end else if (emit_clr) begin
         kind_ff  <= KIND_CLEAR;
         addr_ff  <= '0;
         color_ff <= cfg.bg_color;
         last_ff  <= 1'b1;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.address     = addr_ff;
   assign rsp.pixel_color = color_ff;
   assign rsp.last        = last_ff;

endmodule

`default_nettype wire

### rtl/text_console_glyph_renderer_core.sv
// Top level of the text console glyph renderer: register file, front end, queue, back end.
// Depends on tcgr_pkg, tcgr_if, tcgr_front, tcgr_queue and tcgr_back.
//
// The block turns 1bpp glyph rows into 24-bit pixel writes for a linear framebuffer at
// three bytes per pixel, and keeps a 16-bit text cursor. A request carries one glyph row
// (op row), a newline, or a step back of one glyph. Each row is drawn at the cursor, offset
// down by row_index, leftmost pixel in the highest drawn bit; set bits use the request color,
// clear bits the background register; pixels off the screen produce no response. With
// advance set, the cursor then moves one glyph right, or to a new line when the next glyph
// would not fit. A newline past the bottom produces one clear-screen response (address
// zero, background color) and homes the cursor. The final response of each request carries
// last; requests that cause no response (step back, unused op, rows beyond the glyph or
// below the screen) are not queued. The front end takes one request per cycle into a
// two-entry command queue while the queue is not full, so cursor updates wait on pixel
// output only once it fills. The back end emits one pixel per cycle while responses are
// taken and steps over each drawn pixel position, visible or not: a glyph row occupies it
// for its drawn width (glyph_width rounded down to a multiple of eight, capped at
// MAX_GLYPH_WIDTH), then any clear response; it pops the next command as it finishes.
// Responses leave from a register, so a new request is taken while a result waits.
// Registers are written through csr_wr_en/csr_index/csr_wdata and must only change while
// the block is idle; writes to indexes beyond the register list are ignored.
`default_nettype none

module text_console_glyph_renderer_core #(
   parameter int MAX_GLYPH_WIDTH  = tcgr_pkg::MAX_GLYPH_WIDTH_DEF,
   parameter int MAX_GLYPH_HEIGHT = tcgr_pkg::MAX_GLYPH_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tcgr_req_if.sink                               req_chan,
   tcgr_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [tcgr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tcgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcgr_pkg::*;

   tcgr_cfg_type cfg_ff;
   tcgr_cmd_type push_cmd, head_cmd;
   logic         q_push, q_pop, q_full, q_empty;

   // Configuration registers: mask each write to its register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disp_width   <= DISP_WIDTH_RST;
         cfg_ff.disp_height  <= DISP_HEIGHT_RST;
         cfg_ff.glyph_width  <= GLYPH_WIDTH_RST;
         cfg_ff.glyph_height <= GLYPH_HEIGHT_RST;
         cfg_ff.fb_base      <= FB_BASE_RST;
         cfg_ff.bg_color     <= BG_COLOR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DISP_WIDTH:   cfg_ff.disp_width   <= csr_wdata[DIM_W-1:0];
            CSR_DISP_HEIGHT:  cfg_ff.disp_height  <= csr_wdata[DIM_W-1:0];
            CSR_GLYPH_WIDTH:  cfg_ff.glyph_width  <= csr_wdata[GLYPH_DIM_W-1:0];
            CSR_GLYPH_HEIGHT: cfg_ff.glyph_height <= csr_wdata[GLYPH_DIM_W-1:0];
            CSR_FB_BASE:      cfg_ff.fb_base      <= csr_wdata[ADDR_W-1:0];
            CSR_BG_COLOR:     cfg_ff.bg_color     <= csr_wdata[COLOR_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Front end: cursor keeping and command building
   tcgr_front #(
      .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
      .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   // Hold commands until the back end is free
   tcgr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (push_cmd),
      .pop    (q_pop),
      .rd_cmd (head_cmd),
      .full   (q_full),
      .empty  (q_empty)
   );

   // Back end: per-pixel address and color generation
   tcgr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_cmd   (head_cmd),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

   // Never push into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

   // Never pop an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   // A clear response always ends its request and carries address zero
   a_clear_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_CLEAR)) |->
         (rsp_chan.last && (rsp_chan.address == '0) && (rsp_chan.pixel_color == cfg_ff.bg_color)))
      else $error("malformed clear response");

endmodule

`default_nettype wire
